### src/double_ended_queue_macros.svh
// Assertion macros shared by the deque RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Plain property checked at every clock edge.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;

  // Widths fixed by the channel payloads.
  localparam int CMD_W     = 3;
  localparam int KEY_OUT_W = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  // Width of the kept count, which must hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam logic [KEY_OUT_W-1:0] KEY_EMPTY = '1;

  // Per-cycle operation broadcast to every cell. At most one bit is set.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } cell_ctrl_t;

endpackage

### src/dq_ifs.sv
interface dq_in_if;
  logic                          valid;
  logic                          ready;
  logic [dq_pkg::CMD_W-1:0]      command;
  logic signed [dq_pkg::KEY_OUT_W-1:0] key_in;

  modport source (output valid, command, key_in, input ready);
  modport sink   (input valid, command, key_in, output ready);
endinterface

interface dq_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [dq_pkg::KEY_OUT_W-1:0] key_out;
  logic [dq_pkg::STATUS_W-1:0]   status;
  logic [dq_pkg::COUNT_W-1:0]    count;

  modport source (output valid, key_out, status, count, input ready);
  modport sink   (input valid, key_out, status, count, output ready);
endinterface

### src/double_ended_queue.sv
// Channel | Dir | Payload                      | Handshake
// in_ch   | in  | command, key_in              | valid / ready
// out_ch  | out | key_out, status, count       | valid / ready
//
// One item is taken per clock; its result sits in the output register from the
// next cycle on. The rate is set by the row of cells, which all update together.
// in_ch.ready drops only while a result waits in the output register and out_ch
// does not take it. Synchronous reset empties every cell at once, with no sweep.
`include "double_ended_queue_macros.svh"

module double_ended_queue (
  input logic     clk,
  input logic     rst_n,
  dq_in_if.sink   in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  logic [KEY_WIDTH-1:0] key_w [DEPTH];
  logic [DEPTH-1:0]     valid_w;
  logic [DEPTH-1:0]     last_w;
  logic [KEY_WIDTH-1:0] push_key;
  logic [KEY_WIDTH-1:0] back_key;
  logic                 accept;
  logic                 full;
  logic                 empty;
  cell_ctrl_t           ctrl;

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [KEY_OUT_W-1:0] key_out_r;
  logic [KEY_OUT_W-1:0] key_out_nxt;
  status_t              status_r;
  status_t              status_nxt;
  logic [COUNT_W-1:0]   out_count_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_key    = KEY_WIDTH'($unsigned(in_ch.key_in));

  // Occupied cells always form a prefix of the row.
  assign full  = valid_w[DEPTH-1];
  assign empty = !valid_w[0];

  always_comb begin
    ctrl            = '0;
    ctrl.push_front = accept && (in_ch.command == CMD_PUSH_FRONT) && !full;
    ctrl.push_back  = accept && (in_ch.command == CMD_PUSH_BACK) && !full;
    ctrl.pop_front  = accept && (in_ch.command == CMD_POP_FRONT) && !empty;
    ctrl.pop_back   = accept && (in_ch.command == CMD_POP_BACK) && !empty;
    ctrl.clear      = accept && (in_ch.command == CMD_CLEAR);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    logic                 left_valid;
    logic [KEY_WIDTH-1:0] right_key;
    logic                 right_valid;

    // The front cell sees the incoming key as an always occupied left neighbor.
    if (i == 0) begin : g_front
      assign left_key   = push_key;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_key   = key_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_rear
      assign right_key   = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_key   = key_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    assign last_w[i] = valid_w[i] && !right_valid;

    dq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .push_key    (push_key),
      .left_key    (left_key),
      .left_valid  (left_valid),
      .right_key   (right_key),
      .right_valid (right_valid),
      .key_o       (key_w[i]),
      .valid_o     (valid_w[i])
    );
  end

  // At most one cell is the rear one, so an AND-OR selects its key.
  always_comb begin
    back_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_key = back_key | (key_w[i] & {KEY_WIDTH{last_w[i]}});
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (ctrl.push_front || ctrl.push_back) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop_front || ctrl.pop_back) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    key_out_nxt = '0;
    status_nxt  = STATUS_DONE;
    case (in_ch.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          key_out_nxt = KEY_EMPTY;
          status_nxt  = STATUS_EMPTY;
        end else begin
          key_out_nxt = KEY_OUT_W'(signed'(key_w[0]));
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          key_out_nxt = KEY_EMPTY;
          status_nxt  = STATUS_EMPTY;
        end else begin
          key_out_nxt = KEY_OUT_W'(signed'(back_key));
        end
      end
      default: begin
        key_out_nxt = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_out_r   <= key_out_nxt;
      status_r    <= status_nxt;
      out_count_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.key_out = key_out_r;
  assign out_ch.status  = status_r;
  assign out_ch.count   = out_count_r;

  `DQ_ASSERT(a_count_matches, count_r == CNT_W'($countones(valid_w)), "count differs from occupied cells")
  `DQ_ASSERT(a_prefix, (valid_w & (valid_w + DEPTH'(1))) == '0, "occupied cells are not a prefix")
  `DQ_ASSERT_NEXT(a_empty_pop, accept && empty && (in_ch.command == CMD_POP_BACK || in_ch.command == CMD_POP_FRONT), status_r == STATUS_EMPTY && key_out_r == KEY_EMPTY, "pop on empty not flagged")
  `DQ_ASSERT_NEXT(a_result_held, out_valid_r && !out_ch.ready, out_valid_r && $stable(key_out_r) && $stable(out_count_r), "waiting result lost")

endmodule

### src/dq_cell.sv
module dq_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dq_pkg::cell_ctrl_t           ctrl,
  input  logic [dq_pkg::KEY_WIDTH-1:0] push_key,
  input  logic [dq_pkg::KEY_WIDTH-1:0] left_key,
  input  logic                         left_valid,
  input  logic [dq_pkg::KEY_WIDTH-1:0] right_key,
  input  logic                         right_valid,
  output logic [dq_pkg::KEY_WIDTH-1:0] key_o,
  output logic                         valid_o
);
  import dq_pkg::*;

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;
  logic                 valid_r;
  logic                 valid_nxt;

  // A push at the front shifts the row toward the rear, a pop at the front
  // shifts it toward the front. Back operations touch only the boundary cell.
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.push_front) begin
      key_nxt   = left_key;
      valid_nxt = left_valid;
    end else if (ctrl.push_back && !valid_r && left_valid) begin
      key_nxt   = push_key;
      valid_nxt = 1'b1;
    end else if (ctrl.pop_front) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end else if (ctrl.pop_back && valid_r && !right_valid) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o   = key_r;
  assign valid_o = valid_r;

endmodule
